// ===== hw/rtl/stvn_pkg.sv =====
package stvn_pkg;

    // Default lattice precision in fraction bits.
    localparam int OUT_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_RATE   = 2'd0;
    localparam logic [1:0] REG_DENS   = 2'd1;
    localparam logic [1:0] REG_SMOOTH = 2'd2;

    // Register limits and reset values.
    localparam logic [15:0] RATE_MIN    = 16'd205;
    localparam logic [15:0] RATE_MAX    = 16'd32768;
    localparam logic [15:0] RATE_RST    = 16'd4096;
    localparam logic [12:0] DENS_MIN    = 13'd256;
    localparam logic [12:0] DENS_MAX    = 13'd6144;
    localparam logic [12:0] DENS_RST    = 13'd256;
    localparam logic [16:0] SMOOTH_MAX  = 17'd65536;
    localparam logic [16:0] ONE_Q16     = 17'd65536;

    // Hash constants.
    localparam logic [63:0] HASH_K0 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_K1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_K2 = 64'hc4ceb9fe1a85ec53;

    // Smoothstep constant 3.0 in Q2.16.
    localparam logic [17:0] THREE_Q16 = 18'd196608;

endpackage

// ===== hw/rtl/space_time_value_noise.sv =====
// Bilinear space-time value noise. One item is taken on every clock cycle
// (busy is always low) and its noise value appears on o_noise_value with an
// o_valid strobe once it has passed the registered stages; the pipeline depth
// is set by the two 64-bit avalanche multiplies of the hash, each split into
// 32-bit partial products over two stages. The receiver cannot stall, so each
// result must be captured in its strobe cycle. Configuration writes are always
// ready and are meant to be issued while no item is in flight.
module space_time_value_noise #(
    parameter int OUT_BITS = stvn_pkg::OUT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_position,
    input  logic [7:0]  i_channel,
    input  logic [47:0] i_elapsed_time,
    output logic        o_valid,
    output logic [15:0] o_noise_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import stvn_pkg::*;

    localparam int NSTG = 8;

    // Configuration registers.
    logic [15:0] r_rate;
    logic [12:0] r_dens;
    logic [16:0] r_smooth;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_dens   <= DENS_RST;
            r_smooth <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATE:   r_rate   <= i_cfg_data[15:0];
                REG_DENS:   r_dens   <= i_cfg_data[12:0];
                REG_SMOOTH: r_smooth <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Saturated register values and saturated input position.
    logic [15:0] rate_c;
    logic [12:0] dens_c;
    logic [16:0] smth_c;
    logic [16:0] pos_c;

    assign rate_c = (r_rate < RATE_MIN) ? RATE_MIN : ((r_rate > RATE_MAX) ? RATE_MAX : r_rate);
    assign dens_c = (r_dens < DENS_MIN) ? DENS_MIN : ((r_dens > DENS_MAX) ? DENS_MAX : r_dens);
    assign smth_c = (r_smooth > SMOOTH_MAX) ? SMOOTH_MAX : r_smooth;
    assign pos_c  = (i_position > ONE_Q16) ? ONE_Q16 : i_position;

    // Valid bits travel alongside the stages.
    logic [NSTG-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start};
        end
    end

    // Stage 1: scale time and position.
    logic [63:0] r1_t;
    logic [29:0] r1_x;
    logic [7:0]  r1_chan;

    always_ff @(posedge i_clk) begin
        r1_t    <= 64'(i_elapsed_time) * 64'(rate_c);
        r1_x    <= 30'(pos_c) * 30'(dens_c);
        r1_chan <= i_channel;
    end

    // Stage 2: form the four corner hash seeds and square the fractions.
    logic [35:0] step_s2;
    logic [4:0]  cell_s2;
    logic [63:0] chan_mix;
    logic [63:0] seed [4];
    logic [63:0] r2_v [4];
    logic [15:0] r2_fx;
    logic [15:0] r2_ft;
    logic [15:0] r2_fx2;
    logic [15:0] r2_ft2;

    assign step_s2  = r1_t[63:28];
    assign cell_s2  = r1_x[28:24];
    assign chan_mix = 64'(r1_chan) * HASH_K0;

    always_comb begin
        seed[0] = {27'd0, cell_s2, 32'd0} ^ {28'd0, step_s2}
                  ^ chan_mix;
        seed[1] = {27'd0, cell_s2 + 5'd1, 32'd0} ^ {28'd0, step_s2}
                  ^ chan_mix;
        seed[2] = {27'd0, cell_s2, 32'd0} ^ (64'(step_s2) + 64'd1)
                  ^ chan_mix;
        seed[3] = {27'd0, cell_s2 + 5'd1, 32'd0} ^ (64'(step_s2) + 64'd1)
                  ^ chan_mix;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r2_v[i] <= seed[i] ^ (seed[i] >> 33);
        end
        r2_fx  <= r1_x[23:8];
        r2_ft  <= r1_t[27:12];
        r2_fx2 <= 16'((32'(r1_x[23:8]) * 32'(r1_x[23:8])) >> 16);
        r2_ft2 <= 16'((32'(r1_t[27:12]) * 32'(r1_t[27:12])) >> 16);
    end

    // Stage 3: partial products of the first multiply; finish smoothstep.
    logic [63:0] r3_p0 [4];
    logic [31:0] r3_p1 [4];
    logic [31:0] r3_p2 [4];
    logic [16:0] r3_sx;
    logic [16:0] r3_st;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r3_p0[i] <= 64'(r2_v[i][31:0]) * 64'(HASH_K1[31:0]);
            r3_p1[i] <= 32'(r2_v[i][31:0] * HASH_K1[63:32]);
            r3_p2[i] <= 32'(r2_v[i][63:32] * HASH_K1[31:0]);
        end
        r3_sx <= 17'((34'(r2_fx2) * 34'(THREE_Q16 - 18'({r2_fx, 1'b0}))) >> 16);
        r3_st <= 17'((34'(r2_ft2) * 34'(THREE_Q16 - 18'({r2_ft, 1'b0}))) >> 16);
    end

    // Stage 4: sum the first product, mix, and form the time weight.
    logic [63:0] prod1 [4];
    logic [63:0] r4_v [4];
    logic [16:0] r4_sx;
    logic [16:0] r4_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod1[i] = r3_p0[i] + {r3_p1[i] + r3_p2[i], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r4_v[i] <= prod1[i] ^ (prod1[i] >> 33);
        end
        r4_sx <= r3_sx;
        r4_w  <= 17'((34'(r3_st) * 34'(smth_c)) >> 16);
    end

    // Stage 5: partial products of the second multiply.
    logic [63:0] r5_p0 [4];
    logic [31:0] r5_p1 [4];
    logic [31:0] r5_p2 [4];
    logic [16:0] r5_sx;
    logic [16:0] r5_w;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r5_p0[i] <= 64'(r4_v[i][31:0]) * 64'(HASH_K2[31:0]);
            r5_p1[i] <= 32'(r4_v[i][31:0] * HASH_K2[63:32]);
            r5_p2[i] <= 32'(r4_v[i][63:32] * HASH_K2[31:0]);
        end
        r5_sx <= r4_sx;
        r5_w  <= r4_w;
    end

    // Stage 6: final mix and lattice values.
    logic [63:0] prod2 [4];
    logic [63:0] mix2  [4];
    logic [OUT_BITS-1:0] r6_lat [4];
    logic [16:0] r6_sx;
    logic [16:0] r6_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod2[i] = r5_p0[i] + {r5_p1[i] + r5_p2[i], 32'd0};
            mix2[i]  = prod2[i] ^ (prod2[i] >> 33);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r6_lat[i] <= mix2[i][63 -: OUT_BITS];
        end
        r6_sx <= r5_sx;
        r6_w  <= r5_w;
    end

    // Stage 7: blend along space.
    localparam int BW = OUT_BITS + 18;
    logic [16:0]         inv_sx;
    logic [OUT_BITS-1:0] r7_top;
    logic [OUT_BITS-1:0] r7_bot;
    logic [16:0]         r7_w;

    assign inv_sx = ONE_Q16 - r6_sx;

    always_ff @(posedge i_clk) begin
        r7_top <= OUT_BITS'((BW'(r6_lat[0]) * BW'(inv_sx)
                            + BW'(r6_lat[1]) * BW'(r6_sx)) >> 16);
        r7_bot <= OUT_BITS'((BW'(r6_lat[2]) * BW'(inv_sx)
                            + BW'(r6_lat[3]) * BW'(r6_sx)) >> 16);
        r7_w   <= r6_w;
    end

    // Stage 8: blend along time and rescale to Q0.16.
    logic [OUT_BITS-1:0] tblend;
    logic [15:0]         scaled;
    logic [15:0]         r8_val;

    assign tblend = OUT_BITS'((BW'(r7_top) * BW'(ONE_Q16 - r7_w)
                              + BW'(r7_bot) * BW'(r7_w)) >> 16);

    generate
        if (OUT_BITS >= 16) begin : g_trunc
            assign scaled = tblend[OUT_BITS-1 -: 16];
        end else begin : g_fill
            assign scaled = {tblend, {(16-OUT_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r8_val <= scaled;
    end

    assign o_valid       = r_vld[NSTG-1];
    assign o_noise_value = r8_val;

endmodule
